### rtl/core/fault_event_log_table_defines.svh
// ----------------------------------------------------------------------------
// Fault event log table assertion macros
// Shared property shorthands for the event log table design.
// ----------------------------------------------------------------------------
`ifndef FAULT_EVENT_LOG_TABLE_DEFINES_SVH
`define FAULT_EVENT_LOG_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define FEL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fault_event_log_table: assertion failed");
// Next-cycle implication, disabled during reset.
`define FEL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fault_event_log_table: assertion failed");
`else
`define FEL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FEL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/fel_pkg.sv
// ----------------------------------------------------------------------------
// Fault event log table package
// Depth, field widths, command and result codes, state and control types.
// ----------------------------------------------------------------------------
package fel_pkg;

  localparam int TABLE_DEPTH = 10;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 8;
  localparam int RC_W     = 2;
  localparam int FILL_W   = 4;

  localparam logic [CMD_W-1:0] CMD_REPORT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET_LAST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

  localparam logic [RC_W-1:0] RC_OK        = 2'd0;
  localparam logic [RC_W-1:0] RC_FULL      = 2'd1;
  localparam logic [RC_W-1:0] RC_NOT_FOUND = 2'd2;
  localparam logic [RC_W-1:0] RC_EMPTY     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } fel_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming beat
    logic exec;  // apply the captured command and register the result
  } fel_ctrl_t;

endpackage

### rtl/core/fel_if.sv
// ----------------------------------------------------------------------------
// Fault event log table channel interfaces
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface fel_in_if;
  logic                          valid;
  logic                          ready;
  logic [fel_pkg::CMD_W-1:0]     cmd;
  logic [fel_pkg::ID_W-1:0]      event_id;
  logic [fel_pkg::STATUS_W-1:0]  event_status;

  modport source (output valid, output cmd, output event_id, output event_status,
                  input ready);
  modport sink (input valid, input cmd, input event_id, input event_status,
                output ready);
endinterface

interface fel_out_if;
  logic                          valid;
  logic                          ready;
  logic [fel_pkg::RC_W-1:0]      result_code;
  logic [fel_pkg::ID_W-1:0]      last_id;
  logic [fel_pkg::STATUS_W-1:0]  last_status;
  logic [fel_pkg::FILL_W-1:0]    fill_count;

  modport source (output valid, output result_code, output last_id,
                  output last_status, output fill_count, input ready);
  modport sink (input valid, input result_code, input last_id,
                input last_status, input fill_count, output ready);
endinterface

### rtl/core/fault_event_log_table.sv
// ----------------------------------------------------------------------------
// Fault event log table
// Arrival-ordered table of diagnostic events with report, get-last and
// clear-by-ID commands; clearing compacts the table in one step.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   in_bus    sink       cmd, event_id, event_status
//   out_bus   source     result_code, last_id, last_status, fill_count
//
// Each command goes from its input beat to its result beat in order: the idle
// state captures the beat; the execute state has the datapath match all
// entries in parallel, update the table and register the result; the output
// state offers the result until the sink takes it. The next command is taken
// at the earliest in the cycle after the result beat, not before it.
// Reset empties the table by clearing the entry count; the entry storage
// itself is not cleared and no clearing pass runs. A stalled result simply
// holds the block in its output state until the sink takes the beat.
//
module fault_event_log_table (
  input  logic clk,
  input  logic rst_n,
  fel_in_if.sink    in_bus,
  fel_out_if.source out_bus
);

  fel_pkg::fel_ctrl_t ctrl;

  // The controller sees only the handshakes; the datapath sees only payload
  // and the controller's command struct.
  fel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .ctrl      (ctrl)
  );

  fel_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .cmd          (in_bus.cmd),
    .event_id     (in_bus.event_id),
    .event_status (in_bus.event_status),
    .result_code  (out_bus.result_code),
    .last_id      (out_bus.last_id),
    .last_status  (out_bus.last_status),
    .fill_count   (out_bus.fill_count)
  );

endmodule

### rtl/core/fel_dp.sv
// ----------------------------------------------------------------------------
// Fault event log table datapath
// Entry store, parallel ID match with compaction, and result registers.
// ----------------------------------------------------------------------------
module fel_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fel_pkg::fel_ctrl_t            ctrl,
  input  logic [fel_pkg::CMD_W-1:0]     cmd,
  input  logic [fel_pkg::ID_W-1:0]      event_id,
  input  logic [fel_pkg::STATUS_W-1:0]  event_status,
  output logic [fel_pkg::RC_W-1:0]      result_code,
  output logic [fel_pkg::ID_W-1:0]      last_id,
  output logic [fel_pkg::STATUS_W-1:0]  last_status,
  output logic [fel_pkg::FILL_W-1:0]    fill_count
);

  logic [fel_pkg::CMD_W-1:0]    cmd_r;
  logic [fel_pkg::ID_W-1:0]     id_r;
  logic [fel_pkg::STATUS_W-1:0] st_r;

  logic [fel_pkg::ID_W-1:0]     id_store_r   [fel_pkg::TABLE_DEPTH];
  logic [fel_pkg::ID_W-1:0]     id_store_nxt [fel_pkg::TABLE_DEPTH];
  logic [fel_pkg::STATUS_W-1:0] st_store_r   [fel_pkg::TABLE_DEPTH];
  logic [fel_pkg::STATUS_W-1:0] st_store_nxt [fel_pkg::TABLE_DEPTH];
  logic [fel_pkg::CNT_W-1:0]    count_r, count_nxt;

  logic [fel_pkg::RC_W-1:0]     rc_r, rc_nxt;
  logic [fel_pkg::ID_W-1:0]     last_id_r, last_id_nxt;
  logic [fel_pkg::STATUS_W-1:0] last_st_r, last_st_nxt;
  logic [fel_pkg::FILL_W-1:0]   fill_r, fill_nxt;

  logic [fel_pkg::TABLE_DEPTH-1:0] hit;
  logic [fel_pkg::TABLE_DEPTH-1:0] past_hit;
  logic [fel_pkg::CNT_W-1:0]       cnt_m1;
  logic [fel_pkg::IDX_W-1:0]       last_idx;
  logic                            full;

  assign full     = (count_r >= fel_pkg::CNT_W'(fel_pkg::TABLE_DEPTH));
  assign cnt_m1   = count_r - fel_pkg::CNT_W'(1);
  assign last_idx = cnt_m1[fel_pkg::IDX_W-1:0];

  // past_hit[j] is set once the oldest matching entry lies at or below j.
  always_comb begin
    for (int j = 0; j < fel_pkg::TABLE_DEPTH; j++) begin
      hit[j] = (fel_pkg::CNT_W'(j) < count_r) && (id_store_r[j] == id_r);
    end
    past_hit[0] = hit[0];
    for (int j = 1; j < fel_pkg::TABLE_DEPTH; j++) begin
      past_hit[j] = past_hit[j-1] | hit[j];
    end
  end

  always_comb begin
    for (int j = 0; j < fel_pkg::TABLE_DEPTH; j++) begin
      id_store_nxt[j] = id_store_r[j];
      st_store_nxt[j] = st_store_r[j];
    end
    count_nxt   = count_r;
    rc_nxt      = fel_pkg::RC_OK;
    last_id_nxt = '0;
    last_st_nxt = '0;

    case (cmd_r)
      fel_pkg::CMD_REPORT: begin
        if (full) begin
          rc_nxt = fel_pkg::RC_FULL;
        end else begin
          for (int j = 0; j < fel_pkg::TABLE_DEPTH; j++) begin
            if (count_r == fel_pkg::CNT_W'(j)) begin
              id_store_nxt[j] = id_r;
              st_store_nxt[j] = st_r;
            end
          end
          count_nxt = count_r + fel_pkg::CNT_W'(1);
        end
      end
      fel_pkg::CMD_GET_LAST: begin
        if (count_r == '0) begin
          rc_nxt = fel_pkg::RC_EMPTY;
        end else begin
          last_id_nxt = id_store_r[last_idx];
          last_st_nxt = st_store_r[last_idx];
        end
      end
      fel_pkg::CMD_CLEAR: begin
        if (past_hit[fel_pkg::TABLE_DEPTH-1]) begin
          // Every entry from the match upward takes its upper neighbor.
          for (int j = 0; j < fel_pkg::TABLE_DEPTH - 1; j++) begin
            if (past_hit[j] && (fel_pkg::CNT_W'(j + 1) < count_r)) begin
              id_store_nxt[j] = id_store_r[j+1];
              st_store_nxt[j] = st_store_r[j+1];
            end
          end
          count_nxt = cnt_m1;
        end else begin
          rc_nxt = fel_pkg::RC_NOT_FOUND;
        end
      end
      default: begin
        rc_nxt = fel_pkg::RC_OK;
      end
    endcase

    fill_nxt = fel_pkg::FILL_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= cmd;
      id_r  <= event_id;
      st_r  <= event_status;
    end
    if (ctrl.exec) begin
      for (int j = 0; j < fel_pkg::TABLE_DEPTH; j++) begin
        id_store_r[j] <= id_store_nxt[j];
        st_store_r[j] <= st_store_nxt[j];
      end
      rc_r      <= rc_nxt;
      last_id_r <= last_id_nxt;
      last_st_r <= last_st_nxt;
      fill_r    <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.exec) begin
      count_r <= count_nxt;
    end
  end

  assign result_code = rc_r;
  assign last_id     = last_id_r;
  assign last_status = last_st_r;
  assign fill_count  = fill_r;

endmodule

### rtl/core/fel_ctrl.sv
// ----------------------------------------------------------------------------
// Fault event log table controller
// Sequences capture, execute and result hand-off for one command at a time.
// ----------------------------------------------------------------------------
`include "fault_event_log_table_defines.svh"

module fel_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output fel_pkg::fel_ctrl_t ctrl
);

  fel_pkg::fel_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fel_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = fel_pkg::ST_EXEC;
        end
      end
      fel_pkg::ST_EXEC: begin
        state_nxt = fel_pkg::ST_OUT;
      end
      fel_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = fel_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fel_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ctrl      = '0;
    case (state_r)
      fel_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      fel_pkg::ST_EXEC: begin
        ctrl.exec = 1'b1;
      end
      fel_pkg::ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fel_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted command is always executed in the following cycle.
  `FEL_ASSERT_NXT(a_load_then_exec, clk, rst_n, ctrl.load, ctrl.exec && !in_ready)
  // Execution is followed directly by an offered result.
  `FEL_ASSERT_NXT(a_exec_then_out, clk, rst_n, ctrl.exec, out_valid)
  // No new command is taken while a result is pending.
  `FEL_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid || ctrl.exec, !in_ready)

endmodule

### dv/event_log_checker.sv
// ----------------------------------------------------------------------------
// Fault event log table result checker
// Watches the command and result channels, keeps its own copy of the event
// table, and compares every result beat against the predicted one.
// ----------------------------------------------------------------------------
module event_log_checker
  import fel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  fel_in_if         in_bus,
  fel_out_if        out_bus,
  output int        mismatches,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [RC_W-1:0]     code;
    logic [ID_W-1:0]     id;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill;
  } log_result_t;

  // Shadow copy of the event table, oldest entry at index zero.
  logic [ID_W-1:0]     model_ids    [TABLE_DEPTH];
  logic [STATUS_W-1:0] model_status [TABLE_DEPTH];
  int                  model_count = 0;

  log_result_t expected_results [$];
  int          mismatch_count = 0;
  int          pending_count  = 0;
  int          result_index   = 0;

  assign mismatches  = mismatch_count;
  assign outstanding = pending_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $realtime, result_index, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [ID_W-1:0] got,
                               input logic [ID_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    end
  endtask

  // Applies one command to the shadow table and returns the result it causes.
  function automatic log_result_t apply_log_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [STATUS_W-1:0] status);
    log_result_t r;
    int          hit;
    int          i;
    r   = '0;
    hit = -1;
    case (cmd)
      CMD_REPORT: begin
        if (model_count >= TABLE_DEPTH) begin
          r.code = RC_FULL;
        end else begin
          model_ids[model_count]    = id;
          model_status[model_count] = status;
          model_count++;
        end
      end
      CMD_GET_LAST: begin
        if (model_count == 0) begin
          r.code = RC_EMPTY;
        end else begin
          r.id     = model_ids[model_count-1];
          r.status = model_status[model_count-1];
        end
      end
      CMD_CLEAR: begin
        // Only the oldest matching entry goes; later ones close the gap.
        for (i = 0; i < model_count; i++) begin
          if (hit < 0 && model_ids[i] == id) hit = i;
        end
        if (hit < 0) begin
          r.code = RC_NOT_FOUND;
        end else begin
          for (i = hit; i + 1 < model_count; i++) begin
            model_ids[i]    = model_ids[i+1];
            model_status[i] = model_status[i+1];
          end
          model_count--;
        end
      end
      default: ;
    endcase
    r.fill = model_count[FILL_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    log_result_t want;
    if (!rst_n) begin
      model_count = 0;
      expected_results.delete();
    end else begin
      // The result side goes first, since a result beat always belongs to an
      // older command than a command beat taken at the same edge.
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no command pending");
        end else begin
          want = expected_results.pop_front();
          compare_field("result_code", ID_W'(out_bus.result_code), ID_W'(want.code));
          compare_field("last_id", out_bus.last_id, want.id);
          compare_field("last_status", ID_W'(out_bus.last_status), ID_W'(want.status));
          compare_field("fill_count", ID_W'(out_bus.fill_count), ID_W'(want.fill));
        end
        result_index++;
      end
      if (in_bus.valid && in_bus.ready) begin
        expected_results.push_back(apply_log_command(in_bus.cmd, in_bus.event_id,
                                                     in_bus.event_status));
      end
    end
    pending_count <= expected_results.size();
  end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Fault event log table testbench
// Drives report, get-last, clear and undefined commands into the table under
// varying source gaps and sink stalls; a separate checker predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fel_pkg::*;

  // The package names only the three real commands; the fourth encoding must
  // be accepted and answered without touching the table.
  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;

  localparam int PHASE_ITEMS  = 363;
  localparam int ID_POOL_SIZE = 6;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 8;

  // IDs used to fill the table in the directed part. The repeated value lets
  // a clear show that only the oldest duplicate is removed.
  localparam logic [ID_W-1:0] FILL_IDS [8] = '{
    16'h1234, 16'h5555, 16'h1234, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h1234, 16'h0F0F
  };
  localparam logic [STATUS_W-1:0] FILL_STATUS [8] = '{
    8'h01, 8'h55, 8'h02, 8'hAA, 8'h0F, 8'hF0, 8'h03, 8'h80
  };

  // Idling per phase: none, source gaps only, sink stalls only, both light.
  localparam int IDLE_BY_PHASE  [4] = '{0, 66, 0, 12};
  localparam int STALL_BY_PHASE [4] = '{0, 0, 66, 12};

  logic clk;
  logic rst_n;

  fel_in_if  in_bus ();
  fel_out_if out_bus ();

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int cycle_count        = 0;
  int mismatches;
  int outstanding;

  logic [ID_W-1:0] id_pool [ID_POOL_SIZE];

  fault_event_log_table u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  event_log_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The sink drops ready at random, at the rate the current phase asks for.
  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one command beat and returns at the edge that accepts it. Valid is
  // left high on return: the caller either offers the next beat in the same
  // time step or lowers valid, so valid sees one assignment per step. Idle
  // cycles carry random payload that the block must ignore.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                              input logic [STATUS_W-1:0] status);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_bus.valid        <= 1'b0;
      in_bus.cmd          <= CMD_W'($urandom);
      in_bus.event_id     <= ID_W'($urandom);
      in_bus.event_status <= STATUS_W'($urandom);
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.cmd          <= cmd;
    in_bus.event_id     <= id;
    in_bus.event_status <= status;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Lowers valid and holds the source back until every result has arrived.
  // The checker's count is registered, so the task waits for an edge before its first look.
  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // One random command. While filling, reports dominate so the table reaches
  // full; while draining, clears dominate so it reaches empty again. Most IDs
  // come from a small pool so that clears hit and duplicates pile up.
  task automatic send_random_command(input bit filling);
    int              roll;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    roll = $urandom_range(99);
    if (roll < 3) begin
      cmd = CMD_UNDEFINED;
    end else if (roll < (filling ? 63 : 33)) begin
      cmd = CMD_REPORT;
    end else if (roll < (filling ? 78 : 53)) begin
      cmd = CMD_GET_LAST;
    end else begin
      cmd = CMD_CLEAR;
    end
    if ($urandom_range(9) < 7) begin
      id = id_pool[$urandom_range(ID_POOL_SIZE-1)];
    end else begin
      id = ID_W'($urandom);
    end
    send_command(cmd, id, STATUS_W'($urandom));
  endtask

  initial begin
    int k;
    int phase;
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.cmd          <= CMD_REPORT;
    in_bus.event_id     <= '0;
    in_bus.event_status <= '0;
    for (k = 0; k < ID_POOL_SIZE; k++) id_pool[k] = ID_W'($urandom);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run with no idling. An empty table first: get-last
    // answers empty, a clear finds nothing, an undefined command changes
    // nothing.
    send_command(CMD_GET_LAST, 16'h0000, 8'h00);
    send_command(CMD_CLEAR, 16'h1234, 8'h00);
    send_command(CMD_UNDEFINED, 16'hFFFF, 8'hFF);

    // Field extremes, then fill the table to its depth.
    send_command(CMD_REPORT, 16'h0000, 8'h00);
    send_command(CMD_REPORT, 16'hFFFF, 8'hFF);
    send_command(CMD_GET_LAST, 16'h0000, 8'h00);
    for (k = 0; k < 8; k++) send_command(CMD_REPORT, FILL_IDS[k], FILL_STATUS[k]);

    // Full table: a further report is refused, the undefined command shows the
    // full count, get-last still returns the newest entry.
    send_command(CMD_REPORT, 16'h4321, 8'h11);
    send_command(CMD_UNDEFINED, 16'h0000, 8'h00);
    send_command(CMD_GET_LAST, 16'hFFFF, 8'hFF);

    // Clears: the oldest of three duplicates, the oldest entry of all, an ID
    // that is not there, and the newest entry.
    send_command(CMD_CLEAR, 16'h1234, 8'h00);
    send_command(CMD_CLEAR, 16'h0000, 8'h00);
    send_command(CMD_CLEAR, 16'hBEEF, 8'h00);
    send_command(CMD_GET_LAST, 16'h0000, 8'h00);
    send_command(CMD_CLEAR, 16'h0F0F, 8'h00);
    send_command(CMD_GET_LAST, 16'h0000, 8'h00);

    // The source pauses here until the table has answered everything.
    wait_for_results();

    // Random part, one phase per idling pattern. The mix swings between
    // filling and draining every 30 beats, and the ID pool is refreshed now
    // and then so that every ID bit keeps moving.
    for (phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = IDLE_BY_PHASE[phase];
      receiver_stall_pct = STALL_BY_PHASE[phase];
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 25 == 0) id_pool[$urandom_range(ID_POOL_SIZE-1)] = ID_W'($urandom);
        send_random_command(((k / 30) % 2) == 0);
      end
      wait_for_results();
    end

    // A few more edges so that a stray extra result beat would still be seen.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### fault_event_log_table.f
+incdir+rtl/core
rtl/core/fel_pkg.sv
rtl/core/fel_if.sv
rtl/core/fel_dp.sv
rtl/core/fel_ctrl.sv
rtl/core/fault_event_log_table.sv
dv/event_log_checker.sv
dv/testbench.sv
